>>> hdl/mqpd_pkg.sv
package mqpd_pkg;

  // Bank geometry
  localparam int NUM_QUEUES  = 32;
  localparam int QUEUE_DEPTH = 8;
  localparam int ID_WIDTH    = 16;

  // Fixed field widths of the request and result items
  localparam int QIDX_W   = 5;
  localparam int EID_W    = 16;
  localparam int QCOUNT_W = 4;

  // Derived storage widths
  localparam int QA_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int SLOT_AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);

  typedef enum logic {
    MODE_ADD,
    MODE_TAKE
  } mode_e;

  typedef enum logic [1:0] {
    ST_DONE,
    ST_FULL,
    ST_EMPTY
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DESC,
    S_SLOT
  } state_e;

  // Per-queue ring descriptor
  typedef struct packed {
    logic [PTR_W-1:0] head;
    logic [CNT_W-1:0] count;
  } desc_t;

  typedef struct packed {
    logic             en;
    logic [QA_W-1:0]  addr;
    desc_t            data;
  } desc_wr_t;

  // One stored entry
  typedef struct packed {
    logic                urgent;
    logic [ID_WIDTH-1:0] id;
  } slot_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_AW-1:0] addr;
    slot_t              data;
  } slot_wr_t;

  // Flat slot address of ring position pos in queue q
  function automatic logic [SLOT_AW-1:0] slot_addr(input logic [QA_W-1:0] q,
                                                   input logic [PTR_W-1:0] pos);
    logic [SLOT_AW-1:0] base;
    base = SLOT_AW'(q) * SLOT_AW'(QUEUE_DEPTH);
    return base + SLOT_AW'(pos);
  endfunction

endpackage

>>> hdl/mqpd_intf.sv
interface mqpd_req_if;
  import mqpd_pkg::*;

  logic              valid;
  logic              ready;
  mode_e             mode;
  logic [QIDX_W-1:0] queue_index;
  logic              urgent;
  logic [EID_W-1:0]  entry_id;

  modport source (output valid, mode, queue_index, urgent, entry_id, input ready);
  modport sink   (input valid, mode, queue_index, urgent, entry_id, output ready);
endinterface

interface mqpd_rsp_if;
  import mqpd_pkg::*;

  logic                valid;
  logic                ready;
  status_e             result_status;
  logic [EID_W-1:0]    taken_id;
  logic                taken_urgent;
  logic [QCOUNT_W-1:0] queue_count;

  modport source (output valid, result_status, taken_id, taken_urgent, queue_count,
                  input ready);
  modport sink   (input valid, result_status, taken_id, taken_urgent, queue_count,
                  output ready);
endinterface

>>> hdl/mqpd_desc_store.sv
module mqpd_desc_store (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       rd_en_i,
  input  logic [mqpd_pkg::QA_W-1:0]  rd_addr_i,
  output mqpd_pkg::desc_t            rd_data_o,
  input  mqpd_pkg::desc_wr_t         wr_i
);
  import mqpd_pkg::*;

  desc_t                 mem [NUM_QUEUES];
  logic [NUM_QUEUES-1:0] vld_q;
  desc_t                 rd_data_q;
  logic                  rd_vld_q;

  // Descriptor array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Written flags; an unwritten descriptor reads as an empty queue at head 0
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[wr_i.addr] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

>>> hdl/mqpd_slot_store.sv
module mqpd_slot_store (
  input  logic                          clk_i,
  input  logic                          rd_en_i,
  input  logic [mqpd_pkg::SLOT_AW-1:0]  rd_addr_i,
  output mqpd_pkg::slot_t               rd_data_o,
  input  mqpd_pkg::slot_wr_t            wr_i
);
  import mqpd_pkg::*;

  slot_t mem [NUM_QUEUES * QUEUE_DEPTH];
  slot_t rd_data_q;

  // Entry storage, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/multi_queue_priority_deque.sv
// Bank of bounded deques, NUM_QUEUES rings of QUEUE_DEPTH entries each.
// Request channel req_i: mode (add or take), queue_index, urgent, entry_id.
// An add puts a regular entry at the tail and an urgent one at the head.
// A take pops the head entry. Response channel rsp_o carries one item per
// request: status (done, full, empty), taken id and urgency, and the count
// of the addressed queue after the request.
// From request accept, an add or a rejected request passes through the
// descriptor step S_DESC into the output register; a successful take goes
// through S_DESC and then the slot step S_SLOT. A request is accepted only
// in the idle state, so no new request is taken until the last one is loaded
// into the output register. Descriptor and slot memories have registered reads.
// The response sits in an output register, so the next request is accepted
// while a result waits. If the receiver stalls and a new result is ready,
// the controller holds in place without touching memory until the output
// register frees up.
// Reset clears the controller state, the output valid flag and the descriptor
// written flags; all queues start empty. Slot contents are not reset.
module multi_queue_priority_deque (
  input logic        clk_i,
  input logic        rst_ni,
  mqpd_req_if.sink   req_i,
  mqpd_rsp_if.source rsp_o
);
  import mqpd_pkg::*;

  typedef struct packed {
    mode_e             mode;
    logic [QIDX_W-1:0] queue_index;
    logic              urgent;
    logic [EID_W-1:0]  entry_id;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [EID_W-1:0]    id;
    logic                urgent;
    logic [QCOUNT_W-1:0] count;
  } rsp_t;

  localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [PTR_W:0]   DEPTH_W   = (PTR_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

  state_e   state_q, state_d;
  req_t     req_q;
  rsp_t     rsp_q, rsp_d;
  logic     rsp_vld_q;
  logic     accept, out_free, out_load;

  desc_t    desc_rd;
  desc_wr_t desc_wr;
  slot_t    slot_rd;
  slot_wr_t slot_wr;
  logic     slot_rd_en;
  logic [SLOT_AW-1:0] slot_rd_addr;

  logic [QA_W-1:0]  q_addr;
  logic             in_range;
  logic [PTR_W-1:0] head_dec, head_inc, tail_pos;
  logic [PTR_W:0]   tail_sum;

  assign accept   = req_i.valid && req_i.ready;
  assign out_free = !rsp_vld_q || rsp_o.ready;
  assign q_addr   = QA_W'(req_q.queue_index);
  assign in_range = 32'(req_q.queue_index) < NUM_QUEUES;

  // Ring arithmetic on the fetched descriptor
  assign head_dec = (desc_rd.head == '0) ? PTR_LAST : desc_rd.head - 1'b1;
  assign head_inc = (desc_rd.head == PTR_LAST) ? '0 : desc_rd.head + 1'b1;
  assign tail_sum = {1'b0, desc_rd.head} + (PTR_W + 1)'(desc_rd.count);
  assign tail_pos = (tail_sum >= DEPTH_W) ? PTR_W'(tail_sum - DEPTH_W)
                                          : PTR_W'(tail_sum);

  mqpd_desc_store u_desc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (accept),
    .rd_addr_i(QA_W'(req_i.queue_index)),
    .rd_data_o(desc_rd),
    .wr_i     (desc_wr)
  );

  mqpd_slot_store u_slot (
    .clk_i    (clk_i),
    .rd_en_i  (slot_rd_en),
    .rd_addr_i(slot_rd_addr),
    .rd_data_o(slot_rd),
    .wr_i     (slot_wr)
  );

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, memory accesses and result
  always_comb begin
    state_d      = state_q;
    req_i.ready  = 1'b0;
    out_load     = 1'b0;
    rsp_d        = '0;
    desc_wr      = '0;
    slot_wr      = '0;
    slot_rd_en   = 1'b0;
    slot_rd_addr = slot_addr(q_addr, desc_rd.head);
    desc_wr.addr = q_addr;
    unique case (state_q)
      S_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = S_DESC;
        end
      end
      S_DESC: begin
        if (!in_range) begin
          rsp_d.status = (req_q.mode == MODE_TAKE) ? ST_EMPTY : ST_FULL;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else if (req_q.mode == MODE_ADD) begin
          if (desc_rd.count >= DEPTH_CNT) begin
            rsp_d.status = ST_FULL;
            rsp_d.count  = QCOUNT_W'(desc_rd.count);
          end else begin
            rsp_d.status = ST_DONE;
            rsp_d.count  = QCOUNT_W'(desc_rd.count + 1'b1);
          end
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
            if (desc_rd.count < DEPTH_CNT) begin
              slot_wr.en          = 1'b1;
              slot_wr.addr        = slot_addr(q_addr, req_q.urgent ? head_dec : tail_pos);
              slot_wr.data.id     = ID_WIDTH'(req_q.entry_id);
              slot_wr.data.urgent = req_q.urgent;
              desc_wr.en          = 1'b1;
              desc_wr.data.head   = req_q.urgent ? head_dec : desc_rd.head;
              desc_wr.data.count  = desc_rd.count + 1'b1;
            end
          end
        end else if (desc_rd.count == '0) begin
          rsp_d.status = ST_EMPTY;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = S_IDLE;
          end
        end else begin
          // Pop: fetch the head slot and retire it in the descriptor
          slot_rd_en         = 1'b1;
          desc_wr.en         = 1'b1;
          desc_wr.data.head  = head_inc;
          desc_wr.data.count = desc_rd.count - 1'b1;
          state_d            = S_SLOT;
        end
      end
      S_SLOT: begin
        rsp_d.status = ST_DONE;
        rsp_d.id     = EID_W'(slot_rd.id);
        rsp_d.urgent = slot_rd.urgent;
        rsp_d.count  = QCOUNT_W'(desc_rd.count - 1'b1);
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Request and result capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.mode        <= req_i.mode;
      req_q.queue_index <= req_i.queue_index;
      req_q.urgent      <= req_i.urgent;
      req_q.entry_id    <= req_i.entry_id;
    end
    if (out_load) begin
      rsp_q <= rsp_d;
    end
  end

  // Output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_vld_q <= 1'b0;
    end else if (out_load) begin
      rsp_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_vld_q <= 1'b0;
    end
  end

  assign rsp_o.valid         = rsp_vld_q;
  assign rsp_o.result_status = rsp_q.status;
  assign rsp_o.taken_id      = rsp_q.id;
  assign rsp_o.taken_urgent  = rsp_q.urgent;
  assign rsp_o.queue_count   = rsp_q.count;

  // Checks
  a_accept_to_desc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_DESC)
    else $error("accepted request did not move to descriptor fetch");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_vld_q |-> rsp_q.count <= QCOUNT_W'(QUEUE_DEPTH))
    else $error("reported queue count exceeds depth");

  a_fail_no_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_vld_q && rsp_q.status != ST_DONE) |-> (rsp_q.id == '0 && !rsp_q.urgent))
    else $error("rejected request reports an entry");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (desc_wr.en || slot_wr.en) |-> (in_range && state_q == S_DESC))
    else $error("memory write outside descriptor step or out of range");

endmodule

>>> tb/sv/multi_queue_priority_deque_tb.sv
`timescale 1ns / 100ps

module multi_queue_priority_deque_tb;
  import mqpd_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int SEGMENT_LEN  = 90;
  localparam int HOLD_AT_ITEM = 250;
  localparam int HOLD_CYCLES  = 400;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    mode_e                mode;
    logic [QIDX_W-1:0]    qidx;
    logic                 urgent;
    logic [EID_W-1:0]     id;
  } request_t;

  typedef struct {
    status_e              status;
    logic [EID_W-1:0]     id;
    logic                 urgent;
    logic [QCOUNT_W-1:0]  count;
  } outcome_t;

  typedef struct {
    request_t             req;
    bit                   typed;
    outcome_t             want;
  } stim_row_t;

  logic clk_i;
  logic rst_ni;

  mqpd_req_if req_if ();
  mqpd_rsp_if rsp_if ();

  multi_queue_priority_deque dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // Shadow copy of the queue bank
  slot_t             ring_slot  [NUM_QUEUES*QUEUE_DEPTH];
  logic [PTR_W-1:0]  ring_head  [NUM_QUEUES];
  logic [CNT_W-1:0]  ring_count [NUM_QUEUES];

  outcome_t   pending_outcomes [$];
  stim_row_t  directed_rows [$];

  int unsigned n_sent, n_checked, n_mismatch;
  int unsigned n_adds, n_takes, n_full, n_empty, n_urgent_out;
  bit          calm;
  bit          hold_start;
  bit          rsp_hold;

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected outcome of one request; updates the shadow bank
  function automatic outcome_t predict_deque(input request_t r);
    outcome_t          res;
    logic [PTR_W-1:0]  hd;
    logic [CNT_W-1:0]  cnt;
    logic [PTR_W-1:0]  pos;
    int unsigned       q;
    slot_t             word;
    res = '{ST_DONE, '0, 1'b0, '0};
    q = r.qidx;
    if (q >= NUM_QUEUES) begin
      res.status = (r.mode == MODE_TAKE) ? ST_EMPTY : ST_FULL;
      return res;
    end
    hd  = ring_head[q];
    cnt = ring_count[q];
    if (r.mode == MODE_ADD) begin
      if (cnt >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
        res.count  = QCOUNT_W'(cnt);
        return res;
      end
      // urgent entries go in front of the current head
      if (r.urgent) begin
        hd = hd - 1'b1;
        pos = hd;
        ring_head[q] = hd;
      end else begin
        pos = hd + PTR_W'(cnt);
      end
      ring_slot[q*QUEUE_DEPTH + pos] = '{urgent: r.urgent, id: r.id[ID_WIDTH-1:0]};
      cnt = cnt + 1'b1;
      ring_count[q] = cnt;
      res.count = QCOUNT_W'(cnt);
      return res;
    end
    if (cnt == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    word = ring_slot[q*QUEUE_DEPTH + hd];
    ring_head[q]  = hd + 1'b1;
    cnt           = cnt - 1'b1;
    ring_count[q] = cnt;
    res.id     = EID_W'(word.id);
    res.urgent = word.urgent;
    res.count  = QCOUNT_W'(cnt);
    return res;
  endfunction

  function automatic void note_mismatch(input string what);
    n_mismatch++;
    if (n_mismatch <= MAX_REPORTS)
      $display("[%0t] mismatch: %s", $time, what);
  endfunction

  function automatic string show(input outcome_t o);
    return $sformatf("status=%0d id=%h urgent=%b count=%0d", o.status, o.id, o.urgent,
                     o.count);
  endfunction

  // Compare one response item with the oldest expectation
  function automatic void check_outcome(input outcome_t got);
    outcome_t want;
    if (pending_outcomes.size() == 0) begin
      note_mismatch({"response with nothing pending: ", show(got)});
      return;
    end
    want = pending_outcomes.pop_front();
    n_checked++;
    if (got.status !== want.status || got.id !== want.id ||
        got.urgent !== want.urgent || got.count !== want.count)
      note_mismatch({"expected ", show(want), ", got ", show(got)});
  endfunction

  function automatic void add_row(input mode_e m, input int q, input bit u, input int id,
                                  input bit typed, input status_e st, input int cnt);
    stim_row_t row;
    row.req   = '{m, QIDX_W'(q), u, EID_W'(id)};
    row.typed = typed;
    row.want  = '{st, '0, 1'b0, QCOUNT_W'(cnt)};
    directed_rows.push_back(row);
  endfunction

  // Offer one request; called and returns at a falling edge
  task automatic drive_request(input request_t r, input bit typed, input outcome_t want);
    int unsigned gap;
    outcome_t    pred;
    gap = calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.mode        <= r.mode;
    req_if.queue_index <= r.qidx;
    req_if.urgent      <= r.urgent;
    req_if.entry_id    <= r.id;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pred = predict_deque(r);
    if (typed) pred = want;
    pending_outcomes.push_back(pred);
    n_sent++;
    if (r.mode == MODE_ADD) n_adds++;
    else n_takes++;
    if (pred.status == ST_FULL) n_full++;
    if (pred.status == ST_EMPTY) n_empty++;
    if (r.mode == MODE_TAKE && pred.urgent) n_urgent_out++;
    if (n_sent == HOLD_AT_ITEM) hold_start = 1'b1;
    @(negedge clk_i);
  endtask

  // Main stimulus
  initial begin
    request_t    r;
    outcome_t    none;
    int unsigned seg, add_pct, hot_base;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.mode        = MODE_ADD;
    req_if.queue_index = '0;
    req_if.urgent      = 1'b0;
    req_if.entry_id    = '0;
    rsp_if.ready       = 1'b0;
    calm       = 1'b0;
    hold_start = 1'b0;
    rsp_hold   = 1'b0;
    none       = '{ST_DONE, '0, 1'b0, '0};
    for (int q = 0; q < NUM_QUEUES; q++) begin
      ring_head[q]  = '0;
      ring_count[q] = '0;
    end

    // Directed rows: empty take, urgent ordering, full queue
    add_row(MODE_TAKE, 0, 1'b0, 16'h0000, 1'b1, ST_EMPTY, 0);
    add_row(MODE_ADD, 31, 1'b0, 16'hFFFF, 1'b1, ST_DONE, 1);
    add_row(MODE_ADD, 31, 1'b1, 16'h0000, 1'b1, ST_DONE, 2);
    add_row(MODE_ADD, 31, 1'b1, 16'h1234, 1'b1, ST_DONE, 3);
    repeat (3) add_row(MODE_TAKE, 31, 1'b0, 16'h0000, 1'b0, ST_DONE, 0);
    add_row(MODE_TAKE, 31, 1'b1, 16'hFFFF, 1'b1, ST_EMPTY, 0);
    for (int i = 0; i < QUEUE_DEPTH; i++)
      add_row(MODE_ADD, 7, i[0], 16'hA5A0 ^ (i * 16'h1111), 1'b0, ST_DONE, 0);
    add_row(MODE_ADD, 7, 1'b0, 16'h5A5A, 1'b1, ST_FULL, QUEUE_DEPTH);
    add_row(MODE_ADD, 7, 1'b1, 16'hC3C3, 1'b1, ST_FULL, QUEUE_DEPTH);
    repeat (5) add_row(MODE_TAKE, 7, 1'b0, 16'h0000, 1'b0, ST_DONE, 0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      drive_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

    // Random part: segments cycle through filling, balanced and draining mixes on four hot queues
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      seg      = k / SEGMENT_LEN;
      add_pct  = (seg % 3 == 0) ? 70 : (seg % 3 == 1) ? 50 : 30;
      hot_base = 8 * (seg % 4);
      calm     = (seg % 4 == 2);
      r.mode   = ($urandom_range(0, 99) < add_pct) ? MODE_ADD : MODE_TAKE;
      r.qidx   = ($urandom_range(0, 99) < 65) ? QIDX_W'(hot_base + $urandom_range(0, 3))
                                              : QIDX_W'($urandom_range(0, NUM_QUEUES - 1));
      r.urgent = 1'($urandom_range(0, 1));
      r.id     = EID_W'($urandom);
      drive_request(r, 1'b0, none);
    end
    req_if.valid <= 1'b0;

    // Drain, then allow for the response latency
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Sent %0d requests (%0d adds, %0d takes), %0d responses checked.",
             n_sent, n_adds, n_takes, n_checked);
    $display({"Rejected adds on full queues: %0d, takes on empty queues: %0d, ",
              "urgent entries taken: %0d."}, n_full, n_empty, n_urgent_out);
    if (n_mismatch == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches in total", n_mismatch);
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Response side: random stalls, plus one long hold-off
  initial begin
    outcome_t    got;
    int unsigned gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 15);
      if (gap > 0 || rsp_hold) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
        while (rsp_hold) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (rsp_if.valid !== 1'b1);
      got.status = rsp_if.result_status;
      got.id     = rsp_if.taken_id;
      got.urgent = rsp_if.taken_urgent;
      got.count  = rsp_if.queue_count;
      check_outcome(got);
      @(negedge clk_i);
    end
  end

  // Long receiver stall so the block backs up into its request port
  initial begin
    wait (hold_start);
    @(posedge clk_i);
    rsp_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rsp_hold = 1'b0;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d responses still pending", pending_outcomes.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
